// File: src/two_axis_jog_velocity_interlock_top_macros.svh
// assertion macros for the jog velocity interlock block
// expects aclk and aresetn in the scope where a macro is used
`ifndef TWO_AXIS_JOG_VELOCITY_INTERLOCK_TOP_MACROS_SVH
`define TWO_AXIS_JOG_VELOCITY_INTERLOCK_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define JVI_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define JVI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/jvi_pkg.sv
// shared types and constants for the jog velocity interlock block
// no dependencies
`timescale 1ns / 1ps

package jvi_pkg;

    // fixed field widths
    localparam int NOW_W      = 32;
    localparam int DEB_W      = 16;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int SW_BASE    = NOW_W;   // switch bits follow the timestamp in s_tdata
    localparam int SW_W       = 4;
    localparam int STICK_BASE = SW_BASE + SW_W;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd1;

    // config reset values
    localparam logic [CFG_DATA_W-1:0] MAX_SPEED_RST = 20'd1000;
    localparam logic [DEB_W-1:0]      DEBOUNCE_RST  = 16'd50;

    // result tuser layout
    localparam int TUSER_W         = 2;
    localparam int TUSER_AXIS      = 0;
    localparam int TUSER_HARD_STOP = 1;

    // axis codes
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // debounced switch levels, pos x in the lowest bit
    typedef struct packed {
        logic neg_y;
        logic pos_y;
        logic neg_x;
        logic pos_x;
    } sw_t;

endpackage

// File: src/jvi_debounce.sv
// debounce of one limit switch against the millisecond timestamp
// depends on jvi_pkg
`timescale 1ns / 1ps

module jvi_debounce (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     upd,
    input  logic                     raw,
    input  logic [jvi_pkg::NOW_W-1:0] now,
    input  logic [jvi_pkg::DEB_W-1:0] db_time,
    output logic                     stable
);
    import jvi_pkg::*;

    logic             seen_reg;
    logic [NOW_W-1:0] chg_reg;
    logic             stable_reg;
    logic [NOW_W-1:0] chg_next;
    logic [NOW_W-1:0] elapsed;

    // restart the hold timer on a raw change, accept once held long enough
    always_comb begin
        chg_next = (raw != seen_reg) ? now : chg_reg;
        elapsed  = now - chg_next;
        stable   = (elapsed >= NOW_W'(db_time)) ? raw : stable_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg   <= 1'b1;
            chg_reg    <= '0;
            stable_reg <= 1'b1;
        end else if (upd) begin
            seen_reg   <= raw;
            chg_reg    <= chg_next;
            stable_reg <= stable;
        end
    end

endmodule

// File: src/jvi_scale.sv
// stick code to signed velocity: dead zone, product, reciprocal divide by full scale
// depends on jvi_pkg (timescale only); two register stages driven by the top level
`timescale 1ns / 1ps

module jvi_scale #(
    parameter int ADC_BITS = 6,
    parameter int MS_BITS  = 20
) (
    input  logic                aclk,
    input  logic                ld1,
    input  logic                ld2,
    input  logic [ADC_BITS-1:0] code,
    input  logic [MS_BITS-1:0]  max_speed,
    output logic                vel_neg,
    output logic [MS_BITS-1:0]  vel_mag
);
    import jvi_pkg::*;

    localparam int PW     = ADC_BITS + MS_BITS;
    localparam int FULL_I = (1 << ADC_BITS) - 1;
    // floor(2^PW / full); quotient estimate is exact or one low
    localparam logic [63:0] RECIP = (64'd1 << PW) / 64'(FULL_I);
    localparam logic [ADC_BITS+2:0] LO_LIM = (ADC_BITS+3)'(2 * FULL_I);
    localparam logic [ADC_BITS+2:0] HI_LIM = (ADC_BITS+3)'(3 * FULL_I);
    localparam logic [ADC_BITS:0]   FULL_X = (ADC_BITS+1)'(FULL_I);

    logic [ADC_BITS+2:0] code5;
    logic [ADC_BITS:0]   code2;
    logic                dead;
    logic                neg;
    logic [ADC_BITS:0]   diff_w;
    logic [ADC_BITS-1:0] diff;
    logic [PW-1:0]       prod_next;
    logic [2*PW:0]       recip_prod;

    logic [PW-1:0]  p1_reg;
    logic           neg1_reg;
    logic [PW-1:0]  p2_reg;
    logic           neg2_reg;
    logic [MS_BITS:0] q0_reg;

    logic [PW:0]    qf;
    logic [PW:0]    rem;
    logic [MS_BITS:0] q_fix;

    // dead zone and distance from center
    always_comb begin
        code5  = ((ADC_BITS+3)'(code) << 2) + (ADC_BITS+3)'(code);
        code2  = (ADC_BITS+1)'(code) << 1;
        dead   = !(code5 < LO_LIM || code5 > HI_LIM);
        neg    = code2 < FULL_X;
        diff_w = neg ? (FULL_X - code2) : (code2 - FULL_X);
        diff   = dead ? '0 : diff_w[ADC_BITS-1:0];
        prod_next = PW'(diff) * PW'(max_speed);
    end

    // stage one: distance times full-scale speed
    always_ff @(posedge aclk) begin
        if (ld1) begin
            p1_reg   <= prod_next;
            neg1_reg <= neg;
        end
    end

    // stage two: quotient estimate by reciprocal
    assign recip_prod = (2*PW+1)'(p1_reg) * (2*PW+1)'(RECIP[MS_BITS:0]);

    always_ff @(posedge aclk) begin
        if (ld2) begin
            q0_reg   <= recip_prod[PW +: MS_BITS+1];
            p2_reg   <= p1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // one correction step: q*full as shift and subtract
    always_comb begin
        qf      = ((PW+1)'(q0_reg) << ADC_BITS) - (PW+1)'(q0_reg);
        rem     = (PW+1)'(p2_reg) - qf;
        q_fix   = (rem >= (PW+1)'(FULL_I)) ? (q0_reg + 1'b1) : q0_reg;
        vel_mag = q_fix[MS_BITS-1:0];
        vel_neg = neg2_reg && (vel_mag != '0);
    end

endmodule

// File: src/jvi_cmd.sv
// limit interlock, change detection and the two-word result register
// depends on jvi_pkg
`timescale 1ns / 1ps

module jvi_cmd #(
    parameter int SPEED_BITS = 20,
    parameter int MS_BITS    = 20,
    parameter int M_TDATA_W  = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  jvi_pkg::sw_t                  sw,
    input  logic                          x_neg,
    input  logic [MS_BITS-1:0]            x_mag,
    input  logic                          y_neg,
    input  logic [MS_BITS-1:0]            y_mag,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_TDATA_W-1:0]          m_tdata,  // forward, speed
    output logic [jvi_pkg::TUSER_W-1:0]   m_tuser,  // axis, hard_stop
    output logic                          m_tlast
);
    import jvi_pkg::*;

    // last commanded velocity per axis, sign and magnitude
    logic                  vel_neg_reg [2];
    logic [MS_BITS-1:0]    vel_mag_reg [2];

    // result slots, slot 0 is on the port
    logic                  slot_axis_reg [2];
    logic                  slot_hs_reg   [2];
    logic                  slot_fwd_reg  [2];
    logic                  slot_last_reg [2];
    logic [SPEED_BITS-1:0] slot_spd_reg  [2];
    logic [1:0]            cnt_reg;

    logic                  stop_all;
    logic                  blk [2];
    logic                  tv_neg [2];
    logic [MS_BITS-1:0]    tv_mag [2];
    logic                  chg [2];
    logic                  w_hs [2];
    logic                  w_fwd [2];
    logic [SPEED_BITS-1:0] w_spd [2];
    logic                  load;
    logic                  pop;
    logic                  first;

    // interlock: a hit switch blocks motion toward it, an opposing pair stops all
    always_comb begin
        stop_all = (sw.pos_x && sw.neg_x) || (sw.pos_y && sw.neg_y);
        blk[0] = stop_all || (sw.pos_x && !x_neg && (x_mag != '0)) || (sw.neg_x && x_neg);
        blk[1] = stop_all || (sw.pos_y && !y_neg && (y_mag != '0)) || (sw.neg_y && y_neg);
        tv_mag[0] = blk[0] ? '0 : x_mag;
        tv_mag[1] = blk[1] ? '0 : y_mag;
        tv_neg[0] = x_neg && !blk[0];
        tv_neg[1] = y_neg && !blk[1];
        for (int a = 0; a < 2; a++) begin
            chg[a]   = (tv_mag[a] != vel_mag_reg[a]) || (tv_neg[a] != vel_neg_reg[a]);
            w_hs[a]  = (tv_mag[a] == '0);
            w_fwd[a] = !w_hs[a] && !tv_neg[a];
            w_spd[a] = SPEED_BITS'(tv_mag[a]);
        end
    end

    // handshake: take a word when empty, or when the only word leaves now
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign in_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign load     = in_valid && in_ready;
    assign first    = chg[0] ? AXIS_X : AXIS_Y;

    // result slots and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= {1'b0, chg[0]} + {1'b0, chg[1]};
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_axis_reg[0] <= first;
            slot_hs_reg[0]   <= w_hs[first];
            slot_fwd_reg[0]  <= w_fwd[first];
            slot_spd_reg[0]  <= w_spd[first];
            slot_last_reg[0] <= !(chg[0] && chg[1]);
            slot_axis_reg[1] <= AXIS_Y;
            slot_hs_reg[1]   <= w_hs[1];
            slot_fwd_reg[1]  <= w_fwd[1];
            slot_spd_reg[1]  <= w_spd[1];
            slot_last_reg[1] <= 1'b1;
        end else if (pop) begin
            slot_axis_reg[0] <= slot_axis_reg[1];
            slot_hs_reg[0]   <= slot_hs_reg[1];
            slot_fwd_reg[0]  <= slot_fwd_reg[1];
            slot_spd_reg[0]  <= slot_spd_reg[1];
            slot_last_reg[0] <= slot_last_reg[1];
        end
    end

    // commanded velocity follows every accepted sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 2; a++) begin
                vel_neg_reg[a] <= 1'b0;
                vel_mag_reg[a] <= '0;
            end
        end else if (load) begin
            for (int a = 0; a < 2; a++) begin
                vel_neg_reg[a] <= tv_neg[a];
                vel_mag_reg[a] <= tv_mag[a];
            end
        end
    end

    // port view of slot 0
    always_comb begin
        m_tdata = M_TDATA_W'({slot_spd_reg[0], slot_fwd_reg[0]});
        m_tuser = '0;
        m_tuser[TUSER_AXIS]      = slot_axis_reg[0];
        m_tuser[TUSER_HARD_STOP] = slot_hs_reg[0];
        m_tlast = slot_last_reg[0];
    end

endmodule

// File: src/two_axis_jog_velocity_interlock_top.sv
// A sample passes the input register, the scaling stages and the result register.
// Throughput: one sample per cycle while each causes at most one command word and
// m_tready is high; after a sample that changes both axes the next one waits until
// the first word has left. Reset (aresetn, synchronous, active low): all switches
// read as hit, commanded velocities zero, max_speed = 1000 (low MS_BITS bits), debounce 50 ms.
`timescale 1ns / 1ps

`include "two_axis_jog_velocity_interlock_top_macros.svh"

module two_axis_jog_velocity_interlock_top #(
    parameter int ADC_BITS   = 6,
    parameter int SPEED_BITS = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jvi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jvi_pkg::CFG_DATA_W-1:0]      cfg_data,
    // sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_ms, raw_pos_x, raw_neg_x, raw_pos_y, raw_neg_y, stick_x, stick_y
    input  logic [((jvi_pkg::STICK_BASE+2*ADC_BITS+7)/8)*8-1:0] s_tdata,
    // command stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // forward, speed
    output logic [((SPEED_BITS+1+7)/8)*8-1:0]   m_tdata,
    // axis, hard_stop
    output logic [jvi_pkg::TUSER_W-1:0]         m_tuser,
    output logic                                m_tlast
);
    import jvi_pkg::*;

    localparam int MS_BITS   = (SPEED_BITS < CFG_DATA_W) ? SPEED_BITS : CFG_DATA_W;
    localparam int M_TDATA_W = ((SPEED_BITS + 1 + 7) / 8) * 8;

    logic [MS_BITS-1:0]  max_speed_reg;
    logic [DEB_W-1:0]    debounce_reg;

    logic [NOW_W-1:0]    now0_reg;
    sw_t                 raw0_reg;
    logic [ADC_BITS-1:0] sx0_reg;
    logic [ADC_BITS-1:0] sy0_reg;
    logic                v0_reg;
    sw_t                 sw1_reg;
    logic                v1_reg;
    sw_t                 sw2_reg;
    logic                v2_reg;

    logic                rdy0;
    logic                rdy1;
    logic                rdy2;
    logic                cmd_ready;
    logic                db_upd;
    sw_t                 sw_next;
    logic                x_neg;
    logic                y_neg;
    logic [MS_BITS-1:0]  x_mag;
    logic [MS_BITS-1:0]  y_mag;

    // config registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= MAX_SPEED_RST[MS_BITS-1:0];
            debounce_reg  <= DEBOUNCE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_SPEED: max_speed_reg <= cfg_data[MS_BITS-1:0];
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data[DEB_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline ready chain, a stage loads when empty or draining
    assign rdy2     = !v2_reg || cmd_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0;
    assign db_upd   = v0_reg && rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (rdy0) begin
            now0_reg <= s_tdata[NOW_W-1:0];
            raw0_reg <= sw_t'(s_tdata[SW_BASE +: SW_W]);
            sx0_reg  <= s_tdata[STICK_BASE +: ADC_BITS];
            sy0_reg  <= s_tdata[STICK_BASE + ADC_BITS +: ADC_BITS];
        end
    end

    // switch debounce, one lane per switch
    jvi_debounce u_db_pos_x (
        .aclk(aclk), .aresetn(aresetn), .upd(db_upd), .raw(raw0_reg.pos_x),
        .now(now0_reg), .db_time(debounce_reg), .stable(sw_next.pos_x)
    );
    jvi_debounce u_db_neg_x (
        .aclk(aclk), .aresetn(aresetn), .upd(db_upd), .raw(raw0_reg.neg_x),
        .now(now0_reg), .db_time(debounce_reg), .stable(sw_next.neg_x)
    );
    jvi_debounce u_db_pos_y (
        .aclk(aclk), .aresetn(aresetn), .upd(db_upd), .raw(raw0_reg.pos_y),
        .now(now0_reg), .db_time(debounce_reg), .stable(sw_next.pos_y)
    );
    jvi_debounce u_db_neg_y (
        .aclk(aclk), .aresetn(aresetn), .upd(db_upd), .raw(raw0_reg.neg_y),
        .now(now0_reg), .db_time(debounce_reg), .stable(sw_next.neg_y)
    );

    // switch levels travel alongside the velocity pipeline
    always_ff @(posedge aclk) begin
        if (rdy1) sw1_reg <= sw_next;
        if (rdy2) sw2_reg <= sw1_reg;
    end

    // velocity scaling per axis
    jvi_scale #(.ADC_BITS(ADC_BITS), .MS_BITS(MS_BITS)) u_scale_x (
        .aclk(aclk), .ld1(rdy1), .ld2(rdy2), .code(sx0_reg),
        .max_speed(max_speed_reg), .vel_neg(x_neg), .vel_mag(x_mag)
    );
    jvi_scale #(.ADC_BITS(ADC_BITS), .MS_BITS(MS_BITS)) u_scale_y (
        .aclk(aclk), .ld1(rdy1), .ld2(rdy2), .code(sy0_reg),
        .max_speed(max_speed_reg), .vel_neg(y_neg), .vel_mag(y_mag)
    );

    // interlock and command words
    jvi_cmd #(.SPEED_BITS(SPEED_BITS), .MS_BITS(MS_BITS), .M_TDATA_W(M_TDATA_W)) u_cmd (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v2_reg), .in_ready(cmd_ready), .sw(sw2_reg),
        .x_neg(x_neg), .x_mag(x_mag), .y_neg(y_neg), .y_mag(y_mag),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // checks
    `JVI_ASSERT_IMPL(a_stop_no_motion, m_tvalid && m_tuser[TUSER_HARD_STOP], m_tdata == '0, "hard stop word carries motion")
    `JVI_ASSERT_IMPL(a_x_before_y, m_tvalid && !m_tlast, m_tuser[TUSER_AXIS] == AXIS_X, "non-final word is not for axis X")
    `JVI_ASSERT_IMPL(a_empty_takes, !m_tvalid, s_tready, "input stalled with empty result register")

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the two-axis jog velocity interlock block
// depends on jvi_pkg and two_axis_jog_velocity_interlock_top; predicts every command word
`timescale 1ns / 1ps

module tb_top;
    import jvi_pkg::*;

    localparam int ADC_BITS   = 6;
    localparam int SPEED_BITS = 20;
    localparam int S_W        = ((STICK_BASE + 2*ADC_BITS + 7)/8)*8;
    localparam int M_W        = ((SPEED_BITS + 1 + 7)/8)*8;
    localparam int STICK_FULL = (1 << ADC_BITS) - 1;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    // spare register slots, written to show that they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic                  axis;
        logic                  hard_stop;
        logic                  forward;
        logic [SPEED_BITS-1:0] speed;
        logic                  last;
    } motor_cmd_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata = '0;   // now_ms, pos_x, neg_x, pos_y, neg_y, stick_x, stick_y
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_W-1:0]        m_tdata;        // forward, speed
    logic [TUSER_W-1:0]    m_tuser;        // axis, hard_stop
    logic                  m_tlast;

    two_axis_jog_velocity_interlock_top #(
        .ADC_BITS  (ADC_BITS),
        .SPEED_BITS(SPEED_BITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic [SPEED_BITS-1:0] speed_limit = MAX_SPEED_RST[SPEED_BITS-1:0];
    logic [DEB_W-1:0]      hold_ms = DEBOUNCE_RST;
    logic [3:0]            seen_level = 4'hF;
    logic [NOW_W-1:0]      change_ms [4] = '{default: '0};
    logic [3:0]            stable_level = 4'hF;
    int                    axis_speed_now [2] = '{0, 0};

    motor_cmd_t cmd_expect_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int error_count    = 0;
    int samples_sent   = 0;
    int words_checked  = 0;
    int reg_writes     = 0;
    logic [NOW_W-1:0] clock_ms = '0;

    // debounce one switch, returns the accepted level
    function automatic logic debounce_level(int k, logic raw, logic [NOW_W-1:0] now);
        logic [NOW_W-1:0] elapsed;
        if (raw != seen_level[k]) begin
            seen_level[k] = raw;
            change_ms[k]  = now;
        end
        elapsed = now - change_ms[k];
        if (elapsed >= {16'b0, hold_ms})
            stable_level[k] = seen_level[k];
        return stable_level[k];
    endfunction

    // stick code to signed velocity with the center dead zone
    function automatic int stick_velocity(logic [ADC_BITS-1:0] code);
        int     c;
        longint diff;
        longint mag;
        logic   neg;
        c = code;
        if (c*5 >= 2*STICK_FULL && c*5 <= 3*STICK_FULL)
            return 0;
        neg  = (2*c < STICK_FULL);
        diff = neg ? STICK_FULL - 2*c : 2*c - STICK_FULL;
        mag  = diff * longint'(speed_limit) / STICK_FULL;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    // work out the command words one sample causes
    function automatic void predict_commands(logic [S_W-1:0] word);
        logic [NOW_W-1:0]    now;
        sw_t                 raw;
        logic [3:0]          acc;
        int                  tv [2];
        motor_cmd_t          cmd;
        motor_cmd_t          batch [$];
        now = word[NOW_W-1:0];
        raw = word[SW_BASE +: SW_W];
        acc[0] = debounce_level(0, raw.pos_x, now);
        acc[1] = debounce_level(1, raw.neg_x, now);
        acc[2] = debounce_level(2, raw.pos_y, now);
        acc[3] = debounce_level(3, raw.neg_y, now);
        tv[0] = stick_velocity(word[STICK_BASE +: ADC_BITS]);
        tv[1] = stick_velocity(word[STICK_BASE + ADC_BITS +: ADC_BITS]);
        // a hit switch blocks motion toward it
        if ((acc[0] && tv[0] > 0) || (acc[1] && tv[0] < 0))
            tv[0] = 0;
        if ((acc[2] && tv[1] > 0) || (acc[3] && tv[1] < 0))
            tv[1] = 0;
        // an opposing pair on either axis stops everything
        if ((acc[0] && acc[1]) || (acc[2] && acc[3])) begin
            tv[0] = 0;
            tv[1] = 0;
        end
        for (int a = 0; a < 2; a++) begin
            if (axis_speed_now[a] != tv[a]) begin
                cmd.axis      = (a == 0) ? AXIS_X : AXIS_Y;
                cmd.hard_stop = (tv[a] == 0);
                cmd.forward   = (tv[a] > 0);
                cmd.speed     = SPEED_BITS'((tv[a] > 0) ? tv[a] : -tv[a]);
                cmd.last      = 1'b0;
                batch.push_back(cmd);
                axis_speed_now[a] = tv[a];
            end
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            cmd_expect_q.push_back(batch[i]);
    endfunction

    // receiver stall pattern
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, cmd_expect_q.size());
            $display("two_axis_jog_velocity_interlock_top verification failed");
            $finish;
        end
    end

    // track register writes and samples, check every command word
    always @(posedge aclk) begin
        motor_cmd_t got;
        motor_cmd_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MAX_SPEED)
                    speed_limit = cfg_data[SPEED_BITS-1:0];
                else if (cfg_index == CFG_DEBOUNCE)
                    hold_ms = cfg_data[DEB_W-1:0];
            end
            if (s_tvalid && s_tready)
                predict_commands(s_tdata);
            if (m_tvalid && m_tready) begin
                got.axis      = m_tuser[TUSER_AXIS];
                got.hard_stop = m_tuser[TUSER_HARD_STOP];
                got.forward   = m_tdata[0];
                got.speed     = m_tdata[1 +: SPEED_BITS];
                got.last      = m_tlast;
                words_checked++;
                if (cmd_expect_q.size() == 0) begin
                    error_count++;
                    if (error_count + mismatch_count <= MAX_REPORTS)
                        $display("unexpected command word: axis %0d stop %0d fwd %0d speed %0d",
                                 got.axis, got.hard_stop, got.forward, got.speed);
                end else begin
                    want = cmd_expect_q.pop_front();
                    if (got.axis !== want.axis || got.hard_stop !== want.hard_stop ||
                        got.forward !== want.forward || got.speed !== want.speed ||
                        got.last !== want.last) begin
                        mismatch_count++;
                        if (error_count + mismatch_count <= MAX_REPORTS) begin
                            $display("mismatch: expected axis %0d stop %0d fwd %0d speed %0d last %0d",
                                     want.axis, want.hard_stop, want.forward, want.speed,
                                     want.last);
                            $display("          got      axis %0d stop %0d fwd %0d speed %0d last %0d",
                                     got.axis, got.hard_stop, got.forward, got.speed,
                                     got.last);
                        end
                    end
                end
            end
        end
    end

    // send one sample word, with random idle cycles ahead of it
    task automatic send_sample(logic [NOW_W-1:0] now, sw_t sw,
                               logic [ADC_BITS-1:0] sx, logic [ADC_BITS-1:0] sy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sy, sx, sw, now};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // let every expected word arrive, then the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (cmd_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register write while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // advance the local timestamp and send
    task automatic step_sample(int dt, sw_t sw, int sx, int sy);
        clock_ms += dt;
        send_sample(clock_ms, sw, ADC_BITS'(sx), ADC_BITS'(sy));
    endtask

    // switches read as hit after reset until the raw level holds low
    task automatic test_reset_hold();
        step_sample(10, 4'b0000, 63, 0);
        step_sample(10, 4'b0000, 0, 63);
        step_sample(40, 4'b0000, 63, 0);
    endtask

    // stick extremes and dead zone edges
    task automatic test_stick_mapping();
        step_sample(1, 4'b0000, 0, 63);
        step_sample(1, 4'b0000, 25, 38);
        step_sample(1, 4'b0000, 26, 37);
        step_sample(1, 4'b0000, 31, 32);
        step_sample(1, 4'b0000, 62, 1);
        step_sample(1, 4'b0000, 63, 0);
    endtask

    // zero debounce: every switch and both opposing pairs, taken at once
    task automatic test_limit_switches();
        sw_t sw;
        write_reg(CFG_DEBOUNCE, 20'd0);
        sw = '0; sw.pos_x = 1'b1;
        step_sample(1, sw, 63, 63);
        sw = '0; sw.neg_x = 1'b1;
        step_sample(1, sw, 0, 0);
        sw = '0; sw.pos_y = 1'b1;
        step_sample(1, sw, 0, 63);
        sw = '0; sw.neg_y = 1'b1;
        step_sample(1, sw, 63, 0);
        sw = '0; sw.pos_x = 1'b1; sw.neg_x = 1'b1;
        step_sample(1, sw, 10, 50);
        step_sample(1, 4'b0000, 10, 50);
        sw = '0; sw.pos_y = 1'b1; sw.neg_y = 1'b1;
        step_sample(1, sw, 55, 5);
    endtask

    // elapsed time across the 32-bit timestamp wrap
    task automatic test_timestamp_wrap();
        sw_t sw;
        write_reg(CFG_DEBOUNCE, 20'd50);
        sw = '0; sw.pos_x = 1'b1;
        clock_ms = 32'hFFFF_FFE0;
        step_sample(0, 4'b0000, 63, 20);
        step_sample(0, sw, 63, 20);
        clock_ms = 32'h0000_0012;
        step_sample(0, sw, 63, 20);
        clock_ms = 32'hFFFF_FFFF;
        step_sample(0, 4'b0000, 0, 40);
    endtask

    // zero full-scale speed, spare register slots ignored
    task automatic test_zero_max_speed();
        write_reg(CFG_MAX_SPEED, 20'd0);
        write_reg(CFG_SPARE_2, 20'hFFFFF);
        write_reg(CFG_SPARE_3, 20'h5A5A5);
        step_sample(100, 4'b0000, 0, 63);
        step_sample(100, 4'b0000, 63, 0);
    endtask

    // time step scaled to the current hold time, with rare large jumps
    function automatic logic [NOW_W-1:0] random_dt();
        int r;
        int h;
        r = $urandom_range(99);
        h = hold_ms;
        if (r < 5)
            return $urandom;
        if (r < 30)
            return $urandom_range(2*h + 2, 0);
        return $urandom_range(h/4 + 3, 0);
    endfunction

    function automatic int random_stick(int prev);
        int r;
        r = $urandom_range(99);
        if (r < 15) return prev;
        if (r < 40) begin
            case ($urandom_range(3))
                0: return 0;
                1: return 1;
                2: return STICK_FULL - 1;
                default: return STICK_FULL;
            endcase
        end
        if (r < 60) return $urandom_range(39, 24);
        return $urandom_range(STICK_FULL);
    endfunction

    // held switch levels that change now and then, plus single-sample bounce
    task automatic test_random_phase(int count, int idle_pct, int stall_pct, bit pause_mid);
        sw_t held;
        sw_t sw;
        int  sx;
        int  sy;
        int  k;
        held = '0;
        sx = 32;
        sy = 32;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (pause_mid && i == count/2)
                wait_drained();
            if ($urandom_range(99) < 10) begin
                k = $urandom_range(3);
                held[k] = ($urandom_range(99) < 30);
            end
            sw = held;
            if ($urandom_range(99) < 4)
                sw[$urandom_range(3)] ^= 1'b1;
            sx = random_stick(sx);
            sy = random_stick(sy);
            clock_ms += random_dt();
            send_sample(clock_ms, sw, ADC_BITS'(sx), ADC_BITS'(sy));
        end
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_hold();
        test_stick_mapping();
        test_limit_switches();
        test_timestamp_wrap();
        test_zero_max_speed();

        write_reg(CFG_MAX_SPEED, 20'd1000);
        write_reg(CFG_DEBOUNCE, 20'd50);
        test_random_phase(130, 0, 0, 1'b0);

        write_reg(CFG_MAX_SPEED, 20'hFFFFF);
        write_reg(CFG_DEBOUNCE, 20'd0);
        test_random_phase(130, 77, 0, 1'b1);

        write_reg(CFG_MAX_SPEED, CFG_DATA_W'($urandom_range(20'hFFFFF)));
        write_reg(CFG_DEBOUNCE, 20'd65535);
        test_random_phase(130, 0, 77, 1'b0);

        write_reg(CFG_MAX_SPEED, 20'd1);
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'($urandom_range(20)));
        test_random_phase(60, 19, 19, 1'b0);

        write_reg(CFG_MAX_SPEED, CFG_DATA_W'($urandom_range(20'hFFFFF)));
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'($urandom_range(200)));
        test_random_phase(90, 19, 19, 1'b0);

        if (cmd_expect_q.size() != 0)
            error_count += cmd_expect_q.size();

        $display("covered %0d samples and %0d command words over %0d register writes,",
                 samples_sent, words_checked, reg_writes);
        $display("including reset hold, dead zone edges, limit interlocks and timestamp wrap");
        if (mismatch_count == 0 && error_count == 0) begin
            $display("two_axis_jog_velocity_interlock_top verification clean");
        end else begin
            $display("%0d mismatches, %0d other errors", mismatch_count, error_count);
            $display("two_axis_jog_velocity_interlock_top verification failed");
        end
        $finish;
    end

endmodule
